[src/enhanced_clock_page_replacer_top_macros.svh]
// Assertion macros shared by the replacer sources.
`ifndef ENHANCED_CLOCK_PAGE_REPLACER_TOP_MACROS_SVH
`define ENHANCED_CLOCK_PAGE_REPLACER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define ECPR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ECPR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECPR_ASSERT(name, clk, rst_n, prop, msg)
`define ECPR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[src/ecpr_pkg.sv]
package ecpr_pkg;

  localparam int FRAME_W      = 6;
  localparam int PID_W        = 16;
  localparam int PAGE_W       = 16;
  localparam int NUM_FRAMES_D = 64;

  // frame, owner_pid, page_number, is_write: 39 bits, padded to 40.
  localparam int IN_TDATA_W   = 40;
  // victim_frame, victim_pid, victim_page, victim_dirty: 39 bits, padded to 40.
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic {
    OP_ACCESS  = 1'b0,
    OP_REPLACE = 1'b1
  } op_e;

  // Requests from the top level to the clock unit.
  typedef struct packed {
    logic acc_valid;
    logic acc_write;
    logic start;
  } ecpr_ctl_t;

  // Status from the clock unit back to the top level.
  typedef struct packed {
    logic done;
    logic dirty;
  } ecpr_stat_t;

endpackage

[src/ecpr_clock.sv]
module ecpr_clock #(
  parameter int NUM_FRAMES = ecpr_pkg::NUM_FRAMES_D,
  parameter int FrameW     = $clog2(NUM_FRAMES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ecpr_pkg::ecpr_ctl_t    ctl_i,
  input  logic [FrameW-1:0]      acc_frame_i,
  output ecpr_pkg::ecpr_stat_t   stat_o,
  output logic [FrameW-1:0]      victim_o
);
  import ecpr_pkg::*;

  localparam logic [FrameW-1:0] LastIdx = FrameW'(NUM_FRAMES - 1);

  logic [NUM_FRAMES-1:0] use_q, use_d;
  logic [NUM_FRAMES-1:0] dirty_q, dirty_d;
  logic [FrameW-1:0]     hand_q, hand_d;
  logic [FrameW-1:0]     ptr_q, ptr_d;
  logic [FrameW-1:0]     victim_q, victim_d;
  logic [FrameW-1:0]     ptr_nxt;
  logic                  pass_q, pass_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  vdirty_q, vdirty_d;
  logic                  hit;

  assign ptr_nxt = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
  // Pass zero wants a clean unused frame, pass one a dirty unused frame.
  assign hit     = !use_q[ptr_q] && (dirty_q[ptr_q] == pass_q);

  always_comb begin
    use_d    = use_q;
    dirty_d  = dirty_q;
    hand_d   = hand_q;
    ptr_d    = ptr_q;
    pass_d   = pass_q;
    busy_d   = busy_q;
    victim_d = victim_q;
    vdirty_d = vdirty_q;
    done_d   = 1'b0;
    if (ctl_i.acc_valid) begin
      use_d[acc_frame_i] = 1'b1;
      if (ctl_i.acc_write) begin
        dirty_d[acc_frame_i] = 1'b1;
      end
    end
    if (ctl_i.start) begin
      busy_d = 1'b1;
      ptr_d  = hand_q;
      pass_d = 1'b0;
    end
    if (busy_q) begin
      if (hit) begin
        busy_d         = 1'b0;
        done_d         = 1'b1;
        victim_d       = ptr_q;
        vdirty_d       = dirty_q[ptr_q];
        use_d[ptr_q]   = 1'b0;
        dirty_d[ptr_q] = 1'b0;
        hand_d         = ptr_nxt;
      end else begin
        if (pass_q) begin
          use_d[ptr_q] = 1'b0;
        end
        ptr_d = ptr_nxt;
        // A full turn brings the pointer back to the hand; switch passes there.
        if (ptr_nxt == hand_q) begin
          pass_d = ~pass_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q   <= '0;
      dirty_q <= '0;
      hand_q  <= '0;
      ptr_q   <= '0;
      pass_q  <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      use_q   <= use_d;
      dirty_q <= dirty_d;
      hand_q  <= hand_d;
      ptr_q   <= ptr_d;
      pass_q  <= pass_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
    vdirty_q <= vdirty_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.dirty = vdirty_q;
  assign victim_o     = victim_q;

endmodule

[src/enhanced_clock_page_replacer_top.sv]
// Channel   Dir  Signals                              Beat carries
// s_axis    in   tvalid, tready, tdata[39:0], tuser   one access or replace request
// m_axis    out  tvalid, tready, tdata[39:0]          one victim per replace request
//
// A replace scans the frames in clock order:
// the clock unit tests one frame per cycle, and a scan sees at most three empty passes.
// Reset clears every use and dirty bit and puts the hand on frame 0, with no
// clearing pass; owner and page of a frame hold nothing until it is accessed.
// The result sits in an output register, so accesses go on while it waits;
// a further replace finishes its scan and then waits for that register.
`include "enhanced_clock_page_replacer_top_macros.svh"

module enhanced_clock_page_replacer_top #(
  parameter int NUM_FRAMES = ecpr_pkg::NUM_FRAMES_D
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // frame[5:0], owner_pid[21:6], page_number[37:22], is_write[38], zero[39]
  input  logic [ecpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // victim_frame[5:0], victim_pid[21:6], victim_page[37:22], victim_dirty[38], zero[39]
  output logic [ecpr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import ecpr_pkg::*;

  localparam int FrameW = $clog2(NUM_FRAMES);
  localparam int EntryW = PID_W + PAGE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  ecpr_ctl_t              ctl;
  ecpr_stat_t             stat;
  logic [FrameW-1:0]      victim;
  logic [FrameW-1:0]      acc_idx;
  logic [FRAME_W-1:0]     in_frame;
  logic [PID_W-1:0]       in_pid;
  logic [PAGE_W-1:0]      in_page;
  logic                   in_write;
  logic                   in_beat;
  logic                   in_range;
  logic                   out_free;
  logic [EntryW-1:0]      frame_mem [NUM_FRAMES];
  logic [EntryW-1:0]      rd_q;
  logic [FrameW-1:0]      res_frame_q;
  logic                   res_dirty_q;
  logic                   m_tvalid_q, m_tvalid_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  assign in_frame = s_axis_tdata[FRAME_W-1:0];
  assign in_pid   = s_axis_tdata[FRAME_W +: PID_W];
  assign in_page  = s_axis_tdata[FRAME_W+PID_W +: PAGE_W];
  assign in_write = s_axis_tdata[FRAME_W+PID_W+PAGE_W];
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign in_range = 32'(in_frame) < 32'(NUM_FRAMES);
  assign acc_idx  = FrameW'(in_frame);
  assign out_free = !m_tvalid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Accesses to frames beyond the table are dropped without effect.
  assign ctl.acc_valid = in_beat && (s_axis_tuser == OP_ACCESS) && in_range;
  assign ctl.acc_write = in_write;
  assign ctl.start     = in_beat && (s_axis_tuser == OP_REPLACE);

  ecpr_clock #(
    .NUM_FRAMES (NUM_FRAMES),
    .FrameW     (FrameW)
  ) u_clock (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .acc_frame_i (acc_idx),
    .stat_o      (stat),
    .victim_o    (victim)
  );

  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    if (m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (ctl.start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.acc_valid) begin
      frame_mem[acc_idx] <= {in_page, in_pid};
    end
  end

  // The victim index is stable from the done pulse until the next replace.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && stat.done) begin
      rd_q        <= frame_mem[victim];
      res_frame_q <= victim;
      res_dirty_q <= stat.dirty;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_LOAD) && out_free) begin
      m_tdata_q <= {1'b0, res_dirty_q, rd_q, FRAME_W'(res_frame_q)};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `ECPR_ASSERT(a_done_in_scan, clk_i, rst_ni, stat.done |-> (state_q == ST_SCAN), "victim reported outside a scan")
  `ECPR_ASSERT(a_victim_range, clk_i, rst_ni, stat.done |-> (32'(victim) < 32'(NUM_FRAMES)), "victim index beyond the frame table")
  `ECPR_ASSERT(a_out_from_load, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == ST_LOAD), "result raised without a finished scan")
  `ECPR_ASSERT_ALWAYS(a_no_start_busy, clk_i, ctl.start |-> (state_q == ST_IDLE), "replace started while busy")

endmodule

[tb/ecpr_victim_checker.sv]
module ecpr_victim_checker
  import ecpr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic               dirty;
  } victim_t;

  victim_t            victims_q[$];
  logic               frame_used [NUM_FRAMES_D];
  logic               frame_dirty[NUM_FRAMES_D];
  logic [PID_W-1:0]   frame_pid  [NUM_FRAMES_D];
  logic [PAGE_W-1:0]  frame_page [NUM_FRAMES_D];
  logic [FRAME_W-1:0] hand;
  int                 fails = 0;

  assign fail_count_o = fails;

  // One trip round the clock looking for an unused frame with the wanted dirty bit.
  // Frames passed over lose their use bit when clear_use is set.
  function automatic int sweep_for(logic want_dirty, bit clear_use);
    logic [FRAME_W-1:0] pos;
    pos = hand;
    for (int n = 0; n < NUM_FRAMES_D; n++) begin
      if (!frame_used[pos] && frame_dirty[pos] == want_dirty) begin
        hand = pos + 1'b1;
        return int'(pos);
      end
      if (clear_use) frame_used[pos] = 1'b0;
      pos = pos + 1'b1;
    end
    hand = pos;
    return -1;
  endfunction

  function automatic victim_t pick_victim();
    int      v;
    victim_t r;
    v = -1;
    for (int round = 0; round < 2 && v < 0; round++) begin
      v = sweep_for(1'b0, 1'b0);
      if (v < 0) v = sweep_for(1'b1, 1'b1);
    end
    if (v < 0) v = 0;
    r.frame = v[FRAME_W-1:0];
    r.pid   = frame_pid[v];
    r.page  = frame_page[v];
    r.dirty = frame_dirty[v];
    frame_used[v]  = 1'b0;
    frame_dirty[v] = 1'b0;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    victim_t            want;
    logic [FRAME_W-1:0] f;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES_D; i++) begin
        frame_used[i]  = 1'b0;
        frame_dirty[i] = 1'b0;
      end
      hand = '0;
      victims_q.delete();
    end else begin
      // Outputs come first: a victim beat can never belong to a request taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (victims_q.size() == 0) begin
          $error("victim beat with no replace pending: tdata %h", m_axis_tdata);
          fails++;
        end else begin
          want = victims_q.pop_front();
          check_field("victim_frame", 32'(want.frame), 32'(m_axis_tdata[5:0]));
          check_field("victim_pid", 32'(want.pid), 32'(m_axis_tdata[21:6]));
          check_field("victim_page", 32'(want.page), 32'(m_axis_tdata[37:22]));
          check_field("victim_dirty", 32'(want.dirty), 32'(m_axis_tdata[38]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (op_e'(s_axis_tuser) == OP_REPLACE) begin
          victims_q.push_back(pick_victim());
        end else begin
          f = s_axis_tdata[5:0];
          frame_pid[f]  = s_axis_tdata[21:6];
          frame_page[f] = s_axis_tdata[37:22];
          frame_used[f] = 1'b1;
          if (s_axis_tdata[38]) frame_dirty[f] = 1'b1;
        end
      end
    end
    pending_o = victims_q.size();
  end

endmodule

[tb/tb_enhanced_clock_page_replacer_top.sv]
module tb_enhanced_clock_page_replacer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ecpr_pkg::*;

  localparam int RANDOM_ITEMS = 1220;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     fail_count;
  int                     pending;
  bit                     src_quiet;
  bit                     sink_quiet;

  enhanced_clock_page_replacer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ecpr_victim_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(op_e op, logic [FRAME_W-1:0] frame, logic [PID_W-1:0] pid,
                           logic [PAGE_W-1:0] page, logic wr);
    int gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, wr, page, pid, frame};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin
    int gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_quiet = !sink_quiet;
      gap = sink_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    int                 sent;
    logic               wr;
    logic [FRAME_W-1:0] hot_base;
    logic [FRAME_W-1:0] f;
    op_e                op;

    sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every frame gets an owner before any replace, all of them written, so the
    // first replace has to go through both rounds before it settles on a frame.
    send_beat(OP_ACCESS, 6'd0, 16'h0000, 16'h0000, 1'b1);
    for (int i = 1; i < NUM_FRAMES_D - 1; i++) begin
      send_beat(OP_ACCESS, i[FRAME_W-1:0], 16'($urandom), 16'($urandom), 1'b1);
    end
    send_beat(OP_ACCESS, 6'd63, 16'hffff, 16'hffff, 1'b1);

    send_beat(OP_REPLACE, 6'd0, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_REPLACE, 6'h3f, 16'hffff, 16'hffff, 1'b1);
    send_beat(OP_ACCESS, 6'd2, 16'hffff, 16'h0000, 1'b0);
    send_beat(OP_ACCESS, 6'd3, 16'h0000, 16'hffff, 1'b1);
    send_beat(OP_REPLACE, 6'd3, 16'h1234, 16'h5678, 1'b1);
    send_beat(OP_ACCESS, 6'd0, 16'h00ff, 16'hff00, 1'b0);
    send_beat(OP_ACCESS, 6'd0, 16'hff00, 16'h00ff, 1'b0);
    send_beat(OP_ACCESS, 6'd1, 16'haaaa, 16'h5555, 1'b1);
    send_beat(OP_ACCESS, 6'd63, 16'h5555, 16'haaaa, 1'b1);
    send_beat(OP_REPLACE, 6'd0, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_REPLACE, 6'd0, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_REPLACE, 6'd0, 16'h0000, 16'h0000, 1'b0);
    send_beat(OP_ACCESS, 6'd62, 16'hffff, 16'hffff, 1'b0);
    send_beat(OP_REPLACE, 6'd62, 16'hffff, 16'hffff, 1'b1);
    send_beat(OP_REPLACE, 6'd0, 16'h0000, 16'h0000, 1'b0);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // Touch the whole table so that the next replaces start from a full clock.
        wr = 1'($urandom_range(0, 1));
        for (int i = 0; i < NUM_FRAMES_D; i++) begin
          send_beat(OP_ACCESS, i[FRAME_W-1:0], 16'($urandom), 16'($urandom),
                    ($urandom_range(0, 3) == 0) ? !wr : wr);
        end
        send_beat(OP_REPLACE, 6'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        sent += NUM_FRAMES_D + 1;
      end else begin
        hot_base = 6'($urandom);
        for (int i = 0; i < 20; i++) begin
          op = ($urandom_range(0, 3) == 0) ? OP_REPLACE : OP_ACCESS;
          if ($urandom_range(0, 1) == 0) f = hot_base + 6'($urandom_range(0, 7));
          else f = 6'($urandom);
          send_beat(op, f, 16'($urandom), 16'($urandom), 1'($urandom));
        end
        sent += 20;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[enhanced_clock_page_replacer_top.f]
+incdir+src
src/ecpr_pkg.sv
src/ecpr_clock.sv
src/enhanced_clock_page_replacer_top.sv
tb/ecpr_victim_checker.sv
tb/tb_enhanced_clock_page_replacer_top.sv
